// ----- rtl/sfs_pkg.sv -----
`default_nettype none
package sfs_pkg;

  localparam int unsigned CoordBitsDef = 16;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 12;

  localparam logic [CfgIdxW-1:0] REG_FORWARD_SPEED = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_TURN_SPEED    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_STOP_DISTANCE = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_FRONT_MARGIN  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_HEADING_TOL   = 3'd4;

  localparam logic [9:0]  FORWARD_SPEED_RST = 10'd200;
  localparam logic [10:0] TURN_SPEED_RST    = 11'd300;
  localparam logic [11:0] STOP_DISTANCE_RST = 12'd500;
  localparam logic [11:0] FRONT_MARGIN_RST  = 12'd400;
  localparam logic [9:0]  HEADING_TOL_RST   = 10'd60;

  localparam logic [1:0] MODE_DETECT  = 2'd0;
  localparam logic [1:0] MODE_TURN    = 2'd1;
  localparam logic [1:0] MODE_ADVANCE = 2'd2;

  localparam int unsigned CordicSteps = 18;
  localparam int unsigned AngW = 25;
  localparam logic signed [AngW-1:0] DEG90_FINE = 25'sd2304000;

  // Result entry: linear speed, angular speed, last flag.
  localparam int unsigned ResW = 23;

  // Arctangent of 2^-i in 1/25600 degree.
  function automatic logic signed [AngW-1:0] atan_fine(input logic [4:0] i);
    logic signed [AngW-1:0] r;
    unique case (i)
      5'd0:  r = 25'sd1152000;
      5'd1:  r = 25'sd680065;
      5'd2:  r = 25'sd359328;
      5'd3:  r = 25'sd182400;
      5'd4:  r = 25'sd91554;
      5'd5:  r = 25'sd45822;
      5'd6:  r = 25'sd22916;
      5'd7:  r = 25'sd11459;
      5'd8:  r = 25'sd5730;
      5'd9:  r = 25'sd2865;
      5'd10: r = 25'sd1432;
      5'd11: r = 25'sd716;
      5'd12: r = 25'sd358;
      5'd13: r = 25'sd179;
      5'd14: r = 25'sd90;
      5'd15: r = 25'sd45;
      5'd16: r = 25'sd22;
      5'd17: r = 25'sd11;
      default: r = 25'sd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/scan_free_space_steer_unit.sv -----
`default_nettype none
// Channel   Direction  Handshake             Content
// points    in         push / full           point_x/y/z, scan_end, heading
// commands  out        empty / pop           linear_speed, angular_speed, last_command
// config    in         cfg_valid / cfg_ready register index and write data
//
// The front takes one point per cycle. A scan end is queued for the back, which in detect
// mode runs 18 arctangent iterations of one shared shift-add unit, then angle, quotient,
// target and decision steps (the iterations are skipped when the far point lies on an
// axis), and only the decision step in turn or advance mode. The input stalls only while a scan
// end sits in the front stage with two more queued. Reset restores the register
// defaults, detect mode and cleared scan trackers; no clearing pass is needed.
module scan_free_space_steer_unit #(
  parameter int unsigned COORD_BITS = sfs_pkg::CoordBitsDef
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic signed [COORD_BITS-1:0]      point_x_i,
  input  wire logic signed [COORD_BITS-1:0]      point_y_i,
  input  wire logic signed [COORD_BITS-1:0]      point_z_i,
  input  wire logic                              scan_end_i,
  input  wire logic [15:0]                       heading_i,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic [9:0]                             linear_speed_o,
  output logic signed [11:0]                     angular_speed_o,
  output logic                                   last_command_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [sfs_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [sfs_pkg::CfgDataW-1:0]      cfg_data_i
);
  import sfs_pkg::*;

  localparam int unsigned JobW = 2 * COORD_BITS + 48;

  logic [9:0]  fwd_q;
  logic [10:0] turn_q;
  logic [11:0] stop_q, margin_q;
  logic [9:0]  tol_q;

  logic            job_push, job_full, job_valid, job_pop;
  logic [JobW-1:0] job_in, job_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q    <= FORWARD_SPEED_RST;
      turn_q   <= TURN_SPEED_RST;
      stop_q   <= STOP_DISTANCE_RST;
      margin_q <= FRONT_MARGIN_RST;
      tol_q    <= HEADING_TOL_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_FORWARD_SPEED: fwd_q    <= cfg_data_i[9:0];
        REG_TURN_SPEED:    turn_q   <= cfg_data_i[10:0];
        REG_STOP_DISTANCE: stop_q   <= cfg_data_i;
        REG_FRONT_MARGIN:  margin_q <= cfg_data_i;
        REG_HEADING_TOL:   tol_q    <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  sfs_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .point_z_i      (point_z_i),
    .scan_end_i     (scan_end_i),
    .heading_i      (heading_i),
    .front_margin_i (margin_q),
    .job_push_o     (job_push),
    .job_full_i     (job_full),
    .job_data_o     (job_in)
  );

  sfs_job_queue #(.WIDTH(JobW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .full_o  (job_full),
    .data_i  (job_in),
    .valid_o (job_valid),
    .pop_i   (job_pop),
    .data_o  (job_out)
  );

  sfs_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (job_valid),
    .job_pop_o       (job_pop),
    .job_data_i      (job_out),
    .forward_speed_i (fwd_q),
    .turn_speed_i    (turn_q),
    .stop_distance_i (stop_q),
    .heading_tol_i   (tol_q),
    .empty           (empty),
    .pop             (pop),
    .linear_speed_o  (linear_speed_o),
    .angular_speed_o (angular_speed_o),
    .last_command_o  (last_command_o)
  );

endmodule
`default_nettype wire

// ----- rtl/sfs_front.sv -----
`default_nettype none
module sfs_front #(
  parameter int unsigned COORD_BITS = sfs_pkg::CoordBitsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic signed [COORD_BITS-1:0] point_x_i,
  input  wire logic signed [COORD_BITS-1:0] point_y_i,
  input  wire logic signed [COORD_BITS-1:0] point_z_i,
  input  wire logic                         scan_end_i,
  input  wire logic [15:0]                  heading_i,
  input  wire logic [11:0]                  front_margin_i,
  output logic                              job_push_o,
  input  wire logic                         job_full_i,
  output logic [2*COORD_BITS+47:0]          job_data_o
);
  import sfs_pkg::*;

  localparam int unsigned C = COORD_BITS;
  localparam int unsigned SqW = 2 * C;
  localparam int unsigned SumW = SqW + 2;
  localparam int unsigned ExtW = (SumW > 33) ? SumW : 33;
  localparam int unsigned CmpW = ((C > 12) ? C : 12) + 1;

  logic                 v_q, v_d, end_q;
  logic signed [C-1:0]  x_q, y_q;
  logic [15:0]          hd_q;
  logic signed [SqW-1:0] sqx_q, sqy_q, sqz_q;
  logic                 adv, acc;
  logic [ExtW-1:0]      sum;
  logic [31:0]          pt_sq;
  logic                 is_front;
  logic [31:0]          far_sq_q, far_sq_d, near_q, near_d;
  logic signed [C-1:0]  far_x_q, far_x_d, far_y_q, far_y_d;

  assign adv  = v_q & ~(end_q & job_full_i);
  assign full = v_q & end_q & job_full_i;
  assign acc  = push & ~full;
  assign v_d  = acc | (v_q & ~adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  // First stage squares the coordinates.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      end_q <= scan_end_i;
      x_q   <= point_x_i;
      y_q   <= point_y_i;
      hd_q  <= heading_i;
      sqx_q <= point_x_i * point_x_i;
      sqy_q <= point_y_i * point_y_i;
      sqz_q <= point_z_i * point_z_i;
    end
  end

  always_comb begin
    sum = ExtW'(unsigned'(sqx_q)) + ExtW'(unsigned'(sqy_q)) + ExtW'(unsigned'(sqz_q));
    pt_sq = (|sum[ExtW-1:32]) ? 32'hFFFF_FFFF : sum[31:0];
    is_front = $signed({{(CmpW-C){x_q[C-1]}}, x_q}) >
               $signed({{(CmpW-12){1'b0}}, front_margin_i});
    far_sq_d = far_sq_q;
    far_x_d  = far_x_q;
    far_y_d  = far_y_q;
    near_d   = near_q;
    if (pt_sq > far_sq_q) begin
      far_sq_d = pt_sq;
      far_x_d  = x_q;
      far_y_d  = y_q;
    end
    if (is_front && pt_sq < near_q) begin
      near_d = pt_sq;
    end
  end

  assign job_push_o = adv & end_q;
  assign job_data_o = {far_x_d, far_y_d, near_d, hd_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      far_sq_q <= '0;
      far_x_q  <= '0;
      far_y_q  <= '0;
      near_q   <= 32'hFFFF_FFFF;
    end else if (adv) begin
      if (end_q) begin
        far_sq_q <= '0;
        far_x_q  <= '0;
        far_y_q  <= '0;
        near_q   <= 32'hFFFF_FFFF;
      end else begin
        far_sq_q <= far_sq_d;
        far_x_q  <= far_x_d;
        far_y_q  <= far_y_d;
        near_q   <= near_d;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/sfs_job_queue.sv -----
`default_nettype none
module sfs_job_queue #(
  parameter int unsigned WIDTH = 80
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  output logic                  full_o,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  valid_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o
);
  logic [WIDTH-1:0] mem_q [2];
  logic             wp_q, rp_q;
  logic [1:0]       cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wp_q <= ~wp_q;
      if (do_pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= data_i;
  end

endmodule
`default_nettype wire

// ----- rtl/sfs_back.sv -----
`default_nettype none
module sfs_back #(
  parameter int unsigned COORD_BITS = sfs_pkg::CoordBitsDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       job_valid_i,
  output logic                            job_pop_o,
  input  wire logic [2*COORD_BITS+47:0]   job_data_i,
  input  wire logic [9:0]                 forward_speed_i,
  input  wire logic [10:0]                turn_speed_i,
  input  wire logic [11:0]                stop_distance_i,
  input  wire logic [9:0]                 heading_tol_i,
  output logic                            empty,
  input  wire logic                       pop,
  output logic [9:0]                      linear_speed_o,
  output logic signed [11:0]              angular_speed_o,
  output logic                            last_command_o
);
  import sfs_pkg::*;

  localparam int unsigned C = COORD_BITS;
  localparam int unsigned CW = C + 26;
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CORD = 3'd1;
  localparam logic [2:0] ST_ANG  = 3'd2;
  localparam logic [2:0] ST_DIVQ = 3'd3;
  localparam logic [2:0] ST_TGT  = 3'd4;
  localparam logic [2:0] ST_DEC  = 3'd5;
  // ceil(2^24 / 100); exact for the sums that occur here.
  localparam logic [17:0] RECIP100 = 18'd167773;

  logic [2:0]            st_q;
  logic [1:0]            mode_q;
  logic [15:0]           target_q;
  logic signed [C-1:0]   jx_q, jy_q;
  logic [31:0]           near_q;
  logic [15:0]           hd_q;
  logic signed [CW-1:0]  cx_q, cy_q;
  logic signed [AngW-1:0] z_q;
  logic [4:0]            step_q;
  logic                  spec_q, ay0_q;
  logic [17:0]           s_q;
  logic [11:0]           q_q;

  logic signed [C-1:0]   nx, ny;
  logic [C-1:0]          ax, ay;
  logic signed [CW-1:0]  shx, shy, negy;
  logic signed [AngW-1:0] zc, f;
  logic [16:0]           a;
  logic [35:0]           prod;
  logic [11:0]           deg;
  logic signed [17:0]    diff;
  logic [16:0]           mag;
  logic                  left;
  logic [23:0]           lim;
  logic                  start;

  // Output queue of four entries, written with up to two entries at a time.
  logic [ResW-1:0]       oq_q [4];
  logic [1:0]            owp_q, orp_q;
  logic [2:0]            ocnt_q;
  logic [1:0]            wr_n;
  logic [ResW-1:0]       wr0, wr1;
  logic                  do_pop;

  assign nx = job_data_i[2*C+47:C+48];
  assign ny = job_data_i[C+47:48];
  assign ax = nx[C-1] ? C'(-nx) : C'(nx);
  assign ay = ny[C-1] ? C'(-ny) : C'(ny);
  assign start = (st_q == ST_IDLE) & job_valid_i & (ocnt_q <= 3'd2);
  assign job_pop_o = start;

  always_comb begin
    shx  = cx_q >>> step_q;
    negy = -cy_q;
    shy  = cy_q[CW-1] ? -(negy >>> step_q) : (cy_q >>> step_q);
  end

  always_comb begin
    if (spec_q) begin
      zc = ay0_q ? '0 : DEG90_FINE;
    end else if (z_q < 0) begin
      zc = '0;
    end else if (z_q > DEG90_FINE) begin
      zc = DEG90_FINE;
    end else begin
      zc = z_q;
    end
    if (!jx_q[C-1] && !jy_q[C-1]) f = zc;
    else if (jx_q[C-1] && !jy_q[C-1]) f = AngW'(2 * DEG90_FINE - zc);
    else if (jx_q[C-1]) f = AngW'(2 * DEG90_FINE + zc);
    else f = AngW'(4 * DEG90_FINE - zc);
    a = 17'(f >>> 8);
    if (a >= 17'd36000) a = a - 17'd36000;
    prod = 36'(s_q) * 36'(RECIP100);
    if (q_q >= 12'd720) deg = q_q - 12'd720;
    else if (q_q >= 12'd360) deg = q_q - 12'd360;
    else deg = q_q;
    diff = $signed({2'b00, target_q}) - $signed({2'b00, hd_q});
    mag  = diff[17] ? 17'(-diff) : 17'(diff);
    left = (mag < 17'd18000) ? (diff > 0) : (diff <= 0);
    lim  = 24'(stop_distance_i) * 24'(stop_distance_i);
  end

  // Decision: at most two results per scan end.
  always_comb begin
    wr_n = 2'd0;
    wr0  = '0;
    wr1  = '0;
    if (st_q == ST_DEC) begin
      if (mode_q == MODE_TURN) begin
        if (mag > 17'(heading_tol_i)) begin
          wr_n = 2'd1;
          wr0  = {10'd0, left ? {1'b0, turn_speed_i} : 12'(-{1'b0, turn_speed_i}), 1'b1};
        end else begin
          wr_n = 2'd2;
          wr0  = {10'd0, 12'd0, 1'b0};
          wr1  = (32'(near_q) < 32'(lim)) ? {10'd0, 12'd0, 1'b1}
                                          : {forward_speed_i, 12'd0, 1'b1};
        end
      end else begin
        wr_n = 2'd1;
        wr0  = (near_q < 32'(lim)) ? {10'd0, 12'd0, 1'b1}
                                   : {forward_speed_i, 12'd0, 1'b1};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      mode_q   <= MODE_DETECT;
      target_q <= '0;
    end else begin
      unique case (st_q)
        ST_IDLE: if (start) st_q <= (mode_q == MODE_DETECT) ?
                     ((ax == '0 || ay == '0) ? ST_ANG : ST_CORD) : ST_DEC;
        ST_CORD: if (step_q == 5'(CordicSteps - 1)) st_q <= ST_ANG;
        ST_ANG:  st_q <= ST_DIVQ;
        ST_DIVQ: st_q <= ST_TGT;
        ST_TGT: begin
          st_q     <= ST_DEC;
          target_q <= 16'(deg) * 16'd100;
          mode_q   <= MODE_TURN;
        end
        ST_DEC: begin
          st_q <= ST_IDLE;
          if (mode_q == MODE_TURN) begin
            if (!(mag > 17'(heading_tol_i))) begin
              mode_q <= (near_q < 32'(lim)) ? MODE_DETECT : MODE_ADVANCE;
            end
          end else if (near_q < 32'(lim)) begin
            mode_q <= MODE_DETECT;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      jx_q   <= nx;
      jy_q   <= ny;
      near_q <= job_data_i[47:16];
      hd_q   <= job_data_i[15:0];
      cx_q   <= CW'(ax) <<< 24;
      cy_q   <= CW'(ay) <<< 24;
      z_q    <= '0;
      step_q <= '0;
      spec_q <= (ax == '0) || (ay == '0);
      ay0_q  <= (ay == '0);
    end else if (st_q == ST_CORD) begin
      step_q <= step_q + 5'd1;
      if (!cy_q[CW-1]) begin
        cx_q <= cx_q + shy;
        cy_q <= cy_q - shx;
        z_q  <= z_q + atan_fine(step_q);
      end else begin
        cx_q <= cx_q - shy;
        cy_q <= cy_q + shx;
        z_q  <= z_q - atan_fine(step_q);
      end
    end
    if (st_q == ST_ANG) s_q <= 18'(a) + 18'(hd_q);
    if (st_q == ST_DIVQ) q_q <= 12'(prod >> 24);
  end

  assign empty  = (ocnt_q == 3'd0);
  assign do_pop = pop & ~empty;
  assign {linear_speed_o, angular_speed_o, last_command_o} = oq_q[orp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owp_q  <= '0;
      orp_q  <= '0;
      ocnt_q <= '0;
    end else begin
      owp_q  <= owp_q + wr_n;
      if (do_pop) orp_q <= orp_q + 2'd1;
      ocnt_q <= ocnt_q + 3'(wr_n) - 3'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_n != 2'd0) oq_q[owp_q] <= wr0;
    if (wr_n == 2'd2) oq_q[owp_q + 2'd1] <= wr1;
  end

endmodule
`default_nettype wire
